// File: rtl/ledb_pkg.sv
`timescale 1ns / 1ps

package ledb_pkg;

	// command kinds
	localparam logic [2:0] KIND_PIXEL = 3'd0;
	localparam logic [2:0] KIND_RECT  = 3'd1;
	localparam logic [2:0] KIND_LINE  = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_FILL  = 3'd4;
	localparam logic [2:0] KIND_READ  = 3'd5;

	// plot modes
	localparam logic [1:0] MODE_DRAW   = 2'd0;
	localparam logic [1:0] MODE_ERASE  = 2'd1;
	localparam logic [1:0] MODE_INVERT = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_XBAD  = 3'd1;
	localparam logic [2:0] ST_YBAD  = 3'd2;
	localparam logic [2:0] ST_BOTH  = 3'd3;
	localparam logic [2:0] ST_ORDER = 3'd4;

endpackage

// File: rtl/ledb_ram.sv
`timescale 1ns / 1ps

module ledb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/led_panel_bitmap_draw_engine.sv
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid, cmd_stall | kind mode first_x first_y second_x second_y
//         |           |                      | scan_phase byte_index
// rsp     | out       | rsp_valid, rsp_stall | status frame_byte
//
// one command at a time; each in-phase point is read in S_PT and written back in
// S_WR, and each point outside the scan phase is skipped in S_PT. read byte goes
// through S_RDD; clear, fill, unused kinds, range errors and an out-of-range
// read byte go straight from the accept to S_DONE.
// clear and fill never touch the memory: per-byte valid bits and a fill value
// stand in for its contents, and reset clears them at once (no clearing pass).
// the next command is taken while a finished word waits in the output register;
// a second finished word holds the sequencer until the first one is taken.

module led_panel_bitmap_draw_engine #(
	parameter int PANEL_WIDTH  = 32,
	parameter int PANEL_HEIGHT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] kind,
	input  logic [1:0] mode,
	input  logic [7:0] first_x,
	input  logic [7:0] first_y,
	input  logic [7:0] second_x,
	input  logic [7:0] second_y,
	input  logic [1:0] scan_phase,
	input  logic [3:0] byte_index,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [2:0] status,
	output logic [7:0] frame_byte
);

	localparam int ROW_GROUPS  = PANEL_HEIGHT / 4;
	localparam int FRAME_BYTES = (PANEL_WIDTH / 8) * ROW_GROUPS;
	localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	typedef enum logic [2:0] {S_IDLE, S_PT, S_WR, S_RDD, S_DONE} state_t;

	state_t           state_q;
	logic [2:0]       kind_q;
	logic [1:0]       mode_q;
	logic [1:0]       phase_q;
	logic [2:0]       st_q;
	logic [7:0]       rb_q;
	logic [7:0]       px_q, py_q;
	logic [7:0]       lx_q, rx_q, uy_q, by_q;
	logic             side_q, bph_q;
	logic             steep_q, neg_q;
	logic [7:0]       mstart_q, mend_q, mag_q, dm_q, r_q, q_q;
	logic [AW-1:0]    addr_q;
	logic [FRAME_BYTES-1:0] vld_q;
	logic             fill_q;
	logic             res_valid_q;
	logic [2:0]       res_st_q;
	logic [7:0]       res_fb_q;

	// range checks on both points
	logic       xb1, yb1, xb2, yb2;
	logic [2:0] c1, c2, cpair;
	always_comb begin
		xb1 = {1'b0, first_x} >= 9'(PANEL_WIDTH);
		yb1 = {1'b0, first_y} >= 9'(PANEL_HEIGHT);
		xb2 = {1'b0, second_x} >= 9'(PANEL_WIDTH);
		yb2 = {1'b0, second_y} >= 9'(PANEL_HEIGHT);
		c1 = (xb1 && yb1) ? ledb_pkg::ST_BOTH : xb1 ? ledb_pkg::ST_XBAD :
			yb1 ? ledb_pkg::ST_YBAD : ledb_pkg::ST_OK;
		c2 = (xb2 && yb2) ? ledb_pkg::ST_BOTH : xb2 ? ledb_pkg::ST_XBAD :
			yb2 ? ledb_pkg::ST_YBAD : ledb_pkg::ST_OK;
		cpair = (c1 == c2) ? c1 : ledb_pkg::ST_BOTH;
	end

	// line setup: main axis, start point, minor delta
	logic [7:0] aw, ah;
	logic       l_steep, l_swap;
	logic [7:0] l_sx, l_sy, l_ex, l_ey;
	logic [8:0] l_dmin;
	always_comb begin
		aw = (second_x > first_x) ? second_x - first_x : first_x - second_x;
		ah = (second_y > first_y) ? second_y - first_y : first_y - second_y;
		l_steep = ah > aw;
		l_swap = l_steep ? (first_y > second_y) : (first_x > second_x);
		l_sx = l_swap ? second_x : first_x;
		l_sy = l_swap ? second_y : first_y;
		l_ex = l_swap ? first_x : second_x;
		l_ey = l_swap ? first_y : second_y;
		l_dmin = l_steep ? ({1'b0, l_ex} - {1'b0, l_sx}) : ({1'b0, l_ey} - {1'b0, l_sy});
	end

	// next point of the current shape
	logic       last;
	logic [7:0] nx_px, nx_py;
	logic       nx_side, nx_bph;
	logic [8:0] r_sum;
	logic       r_ge;
	logic [7:0] r_nx, q_nx, minor_nx, cur_main;
	always_comb begin
		r_sum = {1'b0, r_q} + {1'b0, mag_q};
		r_ge = r_sum >= {1'b0, dm_q};
		r_nx = r_ge ? 8'(r_sum - {1'b0, dm_q}) : r_sum[7:0];
		q_nx = q_q + {7'd0, r_ge};
		minor_nx = neg_q ? mstart_q - q_nx : mstart_q + q_nx;
		cur_main = steep_q ? py_q : px_q;
		last = 1'b1;
		nx_px = px_q;
		nx_py = py_q;
		nx_side = 1'b0;
		nx_bph = bph_q;
		case (kind_q)
			ledb_pkg::KIND_RECT: begin
				if (!bph_q) begin
					if (!side_q) begin
						last = 1'b0;
						nx_py = by_q;
						nx_side = 1'b1;
					end else if (px_q != rx_q) begin
						last = 1'b0;
						nx_px = px_q + 8'd1;
						nx_py = uy_q;
					end else if (({1'b0, by_q} + 9'd1) < {1'b0, uy_q}) begin
						last = 1'b0;
						nx_px = lx_q;
						nx_py = by_q + 8'd1;
						nx_bph = 1'b1;
					end
				end else begin
					if (!side_q) begin
						last = 1'b0;
						nx_px = rx_q;
						nx_side = 1'b1;
					end else if (({1'b0, py_q} + 9'd1) < {1'b0, uy_q}) begin
						last = 1'b0;
						nx_px = lx_q;
						nx_py = py_q + 8'd1;
					end
				end
			end
			ledb_pkg::KIND_LINE: begin
				if (cur_main != mend_q) begin
					last = 1'b0;
					if (steep_q) begin
						nx_py = py_q + 8'd1;
						nx_px = minor_nx;
					end else begin
						nx_px = px_q + 8'd1;
						nx_py = minor_nx;
					end
				end
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	// memory access and bit update
	logic          in_phase;
	logic [AW-1:0] pt_addr;
	logic [7:0]    rdata, cur_byte, bitm, new_byte;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic          rd_ok;
	always_comb begin
		in_phase = py_q[1:0] == phase_q;
		pt_addr = AW'(int'(px_q >> 3) * ROW_GROUPS + int'(py_q >> 2));
		cur_byte = vld_q[addr_q] ? rdata : {8{fill_q}};
		bitm = 8'h80 >> px_q[2:0];
		case (mode_q)
			ledb_pkg::MODE_DRAW:   new_byte = cur_byte & ~bitm;
			ledb_pkg::MODE_ERASE:  new_byte = cur_byte | bitm;
			ledb_pkg::MODE_INVERT: new_byte = cur_byte ^ bitm;
			default:               new_byte = cur_byte;
		endcase
		rd_ok = int'(byte_index) < FRAME_BYTES;
		ram_we = state_q == S_WR;
		ram_re = (state_q == S_PT) || (state_q == S_IDLE);
		ram_raddr = (state_q == S_IDLE) ? AW'(byte_index) : pt_addr;
	end

	// command decode at accept: status and first state
	logic [2:0] acc_st;
	state_t     acc_state;
	always_comb begin
		acc_st = ledb_pkg::ST_OK;
		acc_state = S_DONE;
		case (kind)
			ledb_pkg::KIND_PIXEL: begin
				acc_st = c1;
				if (c1 == ledb_pkg::ST_OK) begin
					acc_state = S_PT;
				end
			end
			ledb_pkg::KIND_RECT: begin
				if (c1 != ledb_pkg::ST_OK || c2 != ledb_pkg::ST_OK) begin
					acc_st = cpair;
				end else if (second_x < first_x || first_y < second_y) begin
					acc_st = ledb_pkg::ST_ORDER;
				end else begin
					acc_state = S_PT;
				end
			end
			ledb_pkg::KIND_LINE: begin
				if (c1 != ledb_pkg::ST_OK || c2 != ledb_pkg::ST_OK) begin
					acc_st = cpair;
				end else begin
					acc_state = S_PT;
				end
			end
			ledb_pkg::KIND_READ: begin
				if (rd_ok) begin
					acc_state = S_RDD;
				end
			end
			default: begin
				acc_st = ledb_pkg::ST_OK;
			end
		endcase
	end

	ledb_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(new_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign cmd_stall  = state_q != S_IDLE;
	assign rsp_valid  = res_valid_q;
	assign status     = res_st_q;
	assign frame_byte = res_fb_q;

	// sequencer, shape state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= ledb_pkg::KIND_PIXEL;
			mode_q <= ledb_pkg::MODE_DRAW;
			phase_q <= '0;
			st_q <= ledb_pkg::ST_OK;
			rb_q <= '0;
			px_q <= '0;
			py_q <= '0;
			lx_q <= '0;
			rx_q <= '0;
			uy_q <= '0;
			by_q <= '0;
			side_q <= 1'b0;
			bph_q <= 1'b0;
			steep_q <= 1'b0;
			neg_q <= 1'b0;
			mstart_q <= '0;
			mend_q <= '0;
			mag_q <= '0;
			dm_q <= '0;
			r_q <= '0;
			q_q <= '0;
			addr_q <= '0;
			vld_q <= '0;
			fill_q <= 1'b1;
			res_valid_q <= 1'b0;
			res_st_q <= ledb_pkg::ST_OK;
			res_fb_q <= '0;
		end else begin
			// output word: load a finished word or drop a taken one
			if (state_q == S_DONE && (!res_valid_q || !rsp_stall)) begin
				res_valid_q <= 1'b1;
				res_st_q <= st_q;
				res_fb_q <= rb_q;
			end else if (res_valid_q && !rsp_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						kind_q <= kind;
						mode_q <= mode;
						phase_q <= scan_phase;
						rb_q <= '0;
						st_q <= acc_st;
						px_q <= (kind == ledb_pkg::KIND_LINE) ? l_sx : first_x;
						py_q <= (kind == ledb_pkg::KIND_LINE) ? l_sy : first_y;
						lx_q <= first_x;
						rx_q <= second_x;
						uy_q <= first_y;
						by_q <= second_y;
						side_q <= 1'b0;
						bph_q <= 1'b0;
						addr_q <= AW'(byte_index);
						state_q <= acc_state;
						case (kind)
							ledb_pkg::KIND_LINE: begin
								steep_q <= l_steep;
								neg_q <= l_dmin[8];
								mag_q <= l_dmin[8] ? 8'(-l_dmin) : l_dmin[7:0];
								mstart_q <= l_steep ? l_sx : l_sy;
								mend_q <= l_steep ? l_ey : l_ex;
								dm_q <= l_steep ? l_ey - l_sy : l_ex - l_sx;
								r_q <= (l_steep ? l_ey - l_sy : l_ex - l_sx) >> 1;
								q_q <= '0;
							end
							ledb_pkg::KIND_CLEAR: begin
								vld_q <= '0;
								fill_q <= 1'b1;
							end
							ledb_pkg::KIND_FILL: begin
								vld_q <= '0;
								fill_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_PT: begin
					if (in_phase) begin
						addr_q <= pt_addr;
						state_q <= S_WR;
					end else if (last) begin
						state_q <= S_DONE;
					end else begin
						px_q <= nx_px;
						py_q <= nx_py;
						side_q <= nx_side;
						bph_q <= nx_bph;
						r_q <= r_nx;
						q_q <= q_nx;
					end
				end
				S_WR: begin
					vld_q[addr_q] <= 1'b1;
					if (last) begin
						state_q <= S_DONE;
					end else begin
						px_q <= nx_px;
						py_q <= nx_py;
						side_q <= nx_side;
						bph_q <= nx_bph;
						r_q <= r_nx;
						q_q <= q_nx;
						state_q <= S_PT;
					end
				end
				S_RDD: begin
					rb_q <= cur_byte;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a write back always follows its read
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_PT)
		else $error("write back without read");

	// line remainder stays below the run
	a_line_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PT && kind_q == ledb_pkg::KIND_LINE) |-> (r_q < dm_q || dm_q == 8'd0))
		else $error("line remainder out of range");

	// clear and fill drop every stored byte
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (kind_q == ledb_pkg::KIND_CLEAR || kind_q == ledb_pkg::KIND_FILL)
			&& $past(state_q) == S_IDLE) |-> vld_q == '0)
		else $error("valid bits left after clear or fill");

	// only read-byte returns a nonzero byte
	a_fb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && kind_q != ledb_pkg::KIND_READ) |-> rb_q == 8'd0)
		else $error("frame byte on non-read command");

endmodule
